// ===== hdl/angular_separation_unit_core_assert.svh =====
// Assertion macros for the checker file of the block.
`ifndef ANGULAR_SEPARATION_UNIT_CORE_ASSERT_SVH
`define ANGULAR_SEPARATION_UNIT_CORE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ASU_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define ASU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("assertion failed");

`endif

// ===== hdl/asu_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// asu_pkg
// Shared widths, fixed-point constants, CORDIC angle table and the rounded
// Q30 product used by the angular separation datapath.
// ---------------------------------------------------------------------------
package asu_pkg;

    // Datapath word: Q30 values with CORDIC growth headroom, and phases.
    localparam int W = 34;

    localparam logic signed [W-1:0] GAIN_Q30     = 34'sd652032874;
    localparam logic signed [W-1:0] QUARTER_TURN = 34'sd1073741824;
    localparam logic signed [W-1:0] HALF_TURN    = 34'sd2147483648;
    localparam logic signed [W-1:0] HALF_ULP     = 34'sd536870912;

    // atan(2^-k) in units of 2^32 per turn.
    function automatic logic [31:0] atan_turn(input int k);
        logic [31:0] v;
        unique case (k)
            0:  v = 32'h20000000;  1: v = 32'h12E4051E;
            2:  v = 32'h09FB385B;  3: v = 32'h051111D4;
            4:  v = 32'h028B0D43;  5: v = 32'h0145D7E1;
            6:  v = 32'h00A2F61E;  7: v = 32'h00517C55;
            8:  v = 32'h0028BE53;  9: v = 32'h00145F2F;
            10: v = 32'h000A2F98; 11: v = 32'h000517CC;
            12: v = 32'h00028BE6; 13: v = 32'h000145F3;
            14: v = 32'h0000A2FA; 15: v = 32'h0000517D;
            16: v = 32'h000028BE; 17: v = 32'h0000145F;
            18: v = 32'h00000A30; 19: v = 32'h00000518;
            20: v = 32'h0000028C; 21: v = 32'h00000146;
            22: v = 32'h000000A3; 23: v = 32'h00000051;
            24: v = 32'h00000029; 25: v = 32'h00000014;
            26: v = 32'h0000000A; 27: v = 32'h00000005;
            28: v = 32'h00000003; 29: v = 32'h00000001;
            30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

    // Q30 product, rounded half up.
    function automatic logic signed [W-1:0] qmul(input logic signed [W-1:0] a,
                                                 input logic signed [W-1:0] b);
        logic signed [2*W-1:0] p;
        p = a * b + (2*W)'(HALF_ULP);
        return p[W+29:30];
    endfunction

endpackage

// ===== hdl/asu_cordic_cell.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// asu_cordic_cell
// One CORDIC micro-rotation with its output registers; carries a side word
// along so neighbor data stays aligned with the vector.
// ---------------------------------------------------------------------------
module asu_cordic_cell
    import asu_pkg::*;
#(
    parameter bit VECTOR = 1'b0,
    parameter int SHIFT  = 0,
    parameter int SIDE_W = 1
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic signed [W-1:0] i_x,
    input  logic signed [W-1:0] i_y,
    input  logic signed [W-1:0] i_z,
    input  logic [SIDE_W-1:0]   i_side,
    output logic signed [W-1:0] o_x,
    output logic signed [W-1:0] o_y,
    output logic signed [W-1:0] o_z,
    output logic [SIDE_W-1:0]   o_side
);

    localparam logic signed [W-1:0] ATAN = $signed({{(W-32){1'b0}}, atan_turn(SHIFT)});

    logic                d;
    logic signed [W-1:0] n_x, n_y, n_z;

    // Rotate toward zero angle (rotation) or toward zero y (vectoring).
    always_comb begin
        d = VECTOR ? i_y[W-1] : !i_z[W-1];
        if (d) begin
            n_x = i_x - (i_y >>> SHIFT);
            n_y = i_y + (i_x >>> SHIFT);
            n_z = i_z - ATAN;
        end else begin
            n_x = i_x + (i_y >>> SHIFT);
            n_y = i_y - (i_x >>> SHIFT);
            n_z = i_z + ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_x    <= n_x;
            o_y    <= n_y;
            o_z    <= n_z;
            o_side <= i_side;
        end
    end

endmodule

// ===== hdl/asu_cordic_chain.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// asu_cordic_chain
// A row of CORDIC cells, one micro-rotation per cell, shift index rising
// along the row.
// ---------------------------------------------------------------------------
module asu_cordic_chain
    import asu_pkg::*;
#(
    parameter int STAGES = 24,
    parameter bit VECTOR = 1'b0,
    parameter int SIDE_W = 1
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic signed [W-1:0] i_x,
    input  logic signed [W-1:0] i_y,
    input  logic signed [W-1:0] i_z,
    input  logic [SIDE_W-1:0]   i_side,
    output logic signed [W-1:0] o_x,
    output logic signed [W-1:0] o_y,
    output logic signed [W-1:0] o_z,
    output logic [SIDE_W-1:0]   o_side
);

    logic signed [W-1:0] x [STAGES+1];
    logic signed [W-1:0] y [STAGES+1];
    logic signed [W-1:0] z [STAGES+1];
    logic [SIDE_W-1:0]   s [STAGES+1];

    assign x[0] = i_x;
    assign y[0] = i_y;
    assign z[0] = i_z;
    assign s[0] = i_side;

    for (genvar g = 0; g < STAGES; g++) begin : g_cell
        asu_cordic_cell #(
            .VECTOR(VECTOR),
            .SHIFT (g),
            .SIDE_W(SIDE_W)
        ) u_cell (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_x   (x[g]),
            .i_y   (y[g]),
            .i_z   (z[g]),
            .i_side(s[g]),
            .o_x   (x[g+1]),
            .o_y   (y[g+1]),
            .o_z   (z[g+1]),
            .o_side(s[g+1])
        );
    end

    assign o_x    = x[STAGES];
    assign o_y    = y[STAGES];
    assign o_z    = z[STAGES];
    assign o_side = s[STAGES];

endmodule

// ===== hdl/angular_separation_unit_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// angular_separation_unit_core
// Great-circle separation of two sky positions by the Vincenty formula,
// fully pipelined CORDIC datapath.
// ---------------------------------------------------------------------------
// The block takes one position pair per cycle while not stalled and returns
// one separation per pair, in order. The pipeline holds three rows of CORDIC
// cells: one row for the sines and cosines of both declinations and the
// right ascension difference (three chains side by side), one vectoring row
// for the numerator root and one vectoring row for the arctangent. The whole
// pipeline advances together; it holds only while a finished result waits
// at the output under stall, and then the input side stalls too. Angles are
// 2^ANGLE_BITS units per turn; declinations beyond the poles saturate to
// the pole, and the result saturates to 0 .. 180 degrees.
// ---------------------------------------------------------------------------
module angular_separation_unit_core
    import asu_pkg::*;
#(
    parameter int ANGLE_BITS    = 24,
    parameter int CORDIC_STAGES = 24
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [ANGLE_BITS-1:0]        i_ra_first,
    input  logic signed [ANGLE_BITS-1:0] i_dec_first,
    input  logic [ANGLE_BITS-1:0]        i_ra_second,
    input  logic signed [ANGLE_BITS-1:0] i_dec_second,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [ANGLE_BITS-1:0]        o_separation
);

    localparam int LAT = 3 * CORDIC_STAGES + 9;
    localparam int SH  = 32 - ANGLE_BITS;
    localparam logic signed [32:0] DEC_LIM = 33'sd1 <<< (ANGLE_BITS - 2);
    localparam logic signed [W-1:0] RND =
        (ANGLE_BITS < 32) ? (W'(1) <<< (31 - ANGLE_BITS)) : '0;

    typedef struct packed {
        logic signed [W-1:0] z;
        logic                flip;
    } t_rot_in;

    // Fold a 32-bit-turn phase into +/-90 degrees; flip marks a half turn.
    function automatic t_rot_in fold(input logic [31:0] ph);
        t_rot_in r;
        r.z    = W'($signed(ph));
        r.flip = 1'b0;
        if (r.z > QUARTER_TURN) begin
            r.z    = r.z - HALF_TURN;
            r.flip = 1'b1;
        end else if (r.z < -QUARTER_TURN) begin
            r.z    = r.z + HALF_TURN;
            r.flip = 1'b1;
        end
        return r;
    endfunction

    // Clamp a declination to the poles and scale to 32 bits per turn.
    function automatic logic [31:0] dec_phase(input logic signed [ANGLE_BITS-1:0] d);
        logic signed [32:0] v;
        v = 33'(d);
        if (v > DEC_LIM)  v = DEC_LIM;
        if (v < -DEC_LIM) v = -DEC_LIM;
        v = v <<< SH;
        return v[31:0];
    endfunction

    logic en;
    logic [LAT-1:0] r_vld;

    // Advance everything unless the output holds a stalled result.
    assign en      = !(r_vld[LAT-1] && i_stall);
    assign o_stall = !en;
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    // Front: phases and quadrant fold.
    logic [32:0] ra1_s, ra2_s;
    logic [31:0] dra;
    t_rot_in     n_p1, n_p2, n_pd;
    t_rot_in     r_p1, r_p2, r_pd;

    always_comb begin
        ra1_s = 33'(i_ra_first) << SH;
        ra2_s = 33'(i_ra_second) << SH;
        dra   = ra2_s[31:0] - ra1_s[31:0];
        n_p1  = fold(dec_phase(i_dec_first));
        n_p2  = fold(dec_phase(i_dec_second));
        n_pd  = fold(dra);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p1 <= n_p1;
            r_p2 <= n_p2;
            r_pd <= n_pd;
        end
    end

    // Sine and cosine rows.
    logic signed [W-1:0] c1x, c1y, c2x, c2y, cdx, cdy;
    logic                f1, f2, fd;

    asu_cordic_chain #(.STAGES(CORDIC_STAGES), .VECTOR(1'b0), .SIDE_W(1)) u_rot1 (
        .i_clk(i_clk), .i_en(en), .i_x(GAIN_Q30), .i_y('0), .i_z(r_p1.z),
        .i_side(r_p1.flip), .o_x(c1x), .o_y(c1y), .o_z(), .o_side(f1)
    );
    asu_cordic_chain #(.STAGES(CORDIC_STAGES), .VECTOR(1'b0), .SIDE_W(1)) u_rot2 (
        .i_clk(i_clk), .i_en(en), .i_x(GAIN_Q30), .i_y('0), .i_z(r_p2.z),
        .i_side(r_p2.flip), .o_x(c2x), .o_y(c2y), .o_z(), .o_side(f2)
    );
    asu_cordic_chain #(.STAGES(CORDIC_STAGES), .VECTOR(1'b0), .SIDE_W(1)) u_rotd (
        .i_clk(i_clk), .i_en(en), .i_x(GAIN_Q30), .i_y('0), .i_z(r_pd.z),
        .i_side(r_pd.flip), .o_x(cdx), .o_y(cdy), .o_z(), .o_side(fd)
    );

    // Products, one multiply between registers.
    logic signed [W-1:0] r_s1, r_c1, r_s2, r_c2, r_sd, r_cd;
    logic signed [W-1:0] r_nx2, r_a2, r_b2, r_e2, r_f2, r_cd2;
    logic signed [W-1:0] r_nx3, r_a3, r_e3, r_g3, r_h3;
    logic signed [W-1:0] r_nx4, r_ny4, r_den4;
    logic signed [W-1:0] r_mx, r_my, r_mden;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1   <= f1 ? -c1y : c1y;
            r_c1   <= f1 ? -c1x : c1x;
            r_s2   <= f2 ? -c2y : c2y;
            r_c2   <= f2 ? -c2x : c2x;
            r_sd   <= fd ? -cdy : cdy;
            r_cd   <= fd ? -cdx : cdx;

            r_nx2  <= qmul(r_c2, r_sd);
            r_a2   <= qmul(r_c1, r_s2);
            r_b2   <= qmul(r_s1, r_c2);
            r_e2   <= qmul(r_s1, r_s2);
            r_f2   <= qmul(r_c1, r_c2);
            r_cd2  <= r_cd;

            r_nx3  <= r_nx2;
            r_a3   <= r_a2;
            r_e3   <= r_e2;
            r_g3   <= qmul(r_b2, r_cd2);
            r_h3   <= qmul(r_f2, r_cd2);

            r_nx4  <= r_nx3;
            r_ny4  <= r_a3 - r_g3;
            r_den4 <= r_e3 + r_h3;

            r_mx   <= r_nx4[W-1] ? -r_nx4 : r_nx4;
            r_my   <= r_ny4[W-1] ? -r_ny4 : r_ny4;
            r_mden <= r_den4;
        end
    end

    // Numerator root: vectoring on the absolute components.
    logic signed [W-1:0] mag, mden;

    asu_cordic_chain #(.STAGES(CORDIC_STAGES), .VECTOR(1'b1), .SIDE_W(W)) u_mag (
        .i_clk(i_clk), .i_en(en), .i_x(r_mx), .i_y(r_my), .i_z('0),
        .i_side(r_mden), .o_x(mag), .o_y(), .o_z(), .o_side(mden)
    );

    logic signed [W-1:0] r_num, r_den6;
    logic signed [W-1:0] r_ax, r_ay, r_az;
    logic                r_zero, r_neg;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_num  <= qmul(mag, GAIN_Q30);
            r_den6 <= mden;
            // Turn a left-half vector by -90 degrees, start at a quarter turn.
            if (r_den6[W-1]) begin
                r_ax <= r_num;
                r_ay <= -r_den6;
                r_az <= QUARTER_TURN;
            end else begin
                r_ax <= r_den6;
                r_ay <= r_num;
                r_az <= '0;
            end
            r_zero <= (r_num == '0);
            r_neg  <= r_den6[W-1];
        end
    end

    // Arctangent row.
    logic signed [W-1:0] ang;
    logic [1:0]          flags;

    asu_cordic_chain #(.STAGES(CORDIC_STAGES), .VECTOR(1'b1), .SIDE_W(2)) u_atan (
        .i_clk(i_clk), .i_en(en), .i_x(r_ax), .i_y(r_ay), .i_z(r_az),
        .i_side({r_zero, r_neg}), .o_x(), .o_y(), .o_z(ang), .o_side(flags)
    );

    // Zero numerator picks 0 or 180 degrees; else clamp, then round.
    logic signed [W-1:0] a_sat, a_rnd;
    logic [W-1:0]        a_sh;

    always_comb begin
        if (flags[1]) begin
            a_sat = flags[0] ? HALF_TURN : '0;
        end else if (ang[W-1]) begin
            a_sat = '0;
        end else if (ang > HALF_TURN) begin
            a_sat = HALF_TURN;
        end else begin
            a_sat = ang;
        end
        a_rnd = a_sat + RND;
        a_sh  = a_rnd >> SH;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_separation <= a_sh[ANGLE_BITS-1:0];
        end
    end

endmodule

// ===== hdl/asu_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// asu_checker
// Port-level checks on the angular separation core, bound to the top level.
// ---------------------------------------------------------------------------
`include "angular_separation_unit_core_assert.svh"

module asu_checker #(
    parameter int ANGLE_BITS = 24
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_valid,
    input logic                  o_stall,
    input logic [ANGLE_BITS-1:0] i_ra_first,
    input logic [ANGLE_BITS-1:0] i_dec_first,
    input logic [ANGLE_BITS-1:0] i_ra_second,
    input logic [ANGLE_BITS-1:0] i_dec_second,
    input logic                  o_valid,
    input logic                  i_stall,
    input logic [ANGLE_BITS-1:0] o_separation
);

    localparam logic [ANGLE_BITS:0] MAX_SEP = (ANGLE_BITS + 1)'(1) << (ANGLE_BITS - 1);

    logic [ANGLE_BITS:0] sep_ext;
    assign sep_ext = {1'b0, o_separation};

    // Hold a stalled result transaction.
    `ASU_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid)
    `ASU_ASSERT_NEXT(a_out_stable, o_valid && i_stall, $stable(o_separation))
    // Stall the input exactly while a result waits under stall.
    `ASU_ASSERT_NOW(a_stall_link, 1'b1, o_stall == (o_valid && i_stall))
    // Separation never exceeds half a turn.
    `ASU_ASSERT_NOW(a_sep_range, o_valid, sep_ext <= MAX_SEP)

endmodule

bind angular_separation_unit_core asu_checker #(.ANGLE_BITS(ANGLE_BITS)) u_asu_checker (.*);

// ===== test/angular_separation_unit_core_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// angular_separation_unit_core_tb
// Self-checking bench for the great-circle separation pipeline. A bit-exact
// CORDIC predictor computes each separation from the accepted position pair.
// Directed pairs hit poles, out-of-range declinations, coincident and
// antipodal points. Random pairs follow, with random gaps and output stalls
// on both sides and one long output hold-off that backs up the pipeline.
// ---------------------------------------------------------------------------
module angular_separation_unit_core_tb;
    import asu_pkg::*;

    localparam int AB       = 24;
    localparam int STAGES   = 24;
    localparam int N_RANDOM = 2000;
    localparam int IDLE_MAX = 5000;    // cycles with no transaction at all
    localparam int DRAIN    = 200;     // settle time after the last result

    logic                 i_clk        = 1'b0;
    logic                 i_rst_n      = 1'b0;
    logic                 i_valid      = 1'b0;
    logic                 i_stall      = 1'b0;
    logic [AB-1:0]        i_ra_first   = '0;
    logic signed [AB-1:0] i_dec_first  = '0;
    logic [AB-1:0]        i_ra_second  = '0;
    logic signed [AB-1:0] i_dec_second = '0;
    logic                 o_stall;
    logic                 o_valid;
    logic [AB-1:0]        o_separation;

    always #1 i_clk = ~i_clk;

    angular_separation_unit_core #(
        .ANGLE_BITS   (AB),
        .CORDIC_STAGES(STAGES)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_ra_first  (i_ra_first),
        .i_dec_first (i_dec_first),
        .i_ra_second (i_ra_second),
        .i_dec_second(i_dec_second),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_separation(o_separation)
    );

    // -----------------------------------------------------------------------
    // Separation predictor and store of pending separations
    // -----------------------------------------------------------------------
    class separation_scoreboard;
        logic [AB-1:0] pending_sep[$];
        int            n_errors  = 0;
        int            n_checked = 0;
        longint        arctab[STAGES];

        function void load_table();
            longint t[32] = '{
                64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
                64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
                64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
                64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D,
                64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
                64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051,
                64'h00000029, 64'h00000014, 64'h0000000A, 64'h00000005,
                64'h00000003, 64'h00000001, 64'h00000001, 64'h00000000};
            for (int k = 0; k < STAGES; k++) arctab[k] = t[k % 32];
        endfunction

        function longint qprod(longint a, longint b);
            return (a * b + (64'sd1 <<< 29)) >>> 30;
        endfunction

        function void rotate(logic [31:0] phase, output longint s, output longint c);
            longint z, x, y, nx;
            bit     flip;
            z = longint'({32'b0, phase});
            x = 652032874;
            y = 0;
            flip = 0;
            if (z >= (64'sd1 <<< 31)) z -= (64'sd1 <<< 32);
            if (z > (64'sd1 <<< 30)) begin
                z -= (64'sd1 <<< 31);
                flip = 1;
            end else if (z < -(64'sd1 <<< 30)) begin
                z += (64'sd1 <<< 31);
                flip = 1;
            end
            for (int k = 0; k < STAGES; k++) begin
                if (z >= 0) begin
                    nx = x - (y >>> k);
                    y  = y + (x >>> k);
                    z -= arctab[k];
                end else begin
                    nx = x + (y >>> k);
                    y  = y - (x >>> k);
                    z += arctab[k];
                end
                x = nx;
            end
            s = flip ? -y : y;
            c = flip ? -x : x;
        endfunction

        function void vector(longint xi, longint yi, output longint mag, output longint ang);
            longint x, y, z, nx;
            x = xi;
            y = yi;
            z = 0;
            // turn a left-half vector into the right half first
            if (x < 0) begin
                x = yi;
                y = -xi;
                z = 64'sd1 <<< 30;
            end
            for (int k = 0; k < STAGES; k++) begin
                if (y >= 0) begin
                    nx = x + (y >>> k);
                    y  = y - (x >>> k);
                    z += arctab[k];
                end else begin
                    nx = x - (y >>> k);
                    y  = y + (x >>> k);
                    z -= arctab[k];
                end
                x = nx;
            end
            mag = x;
            ang = z;
        endfunction

        function logic [31:0] dec_turns(logic signed [AB-1:0] d);
            longint v;
            v = longint'(d);
            if (v > (64'sd1 <<< (AB-2))) v = 64'sd1 <<< (AB-2);
            if (v < -(64'sd1 <<< (AB-2))) v = -(64'sd1 <<< (AB-2));
            v = v * (64'sd1 <<< (32-AB));
            return v[31:0];
        endfunction

        function void note_pair(logic [AB-1:0] ra1, logic signed [AB-1:0] d1,
                                logic [AB-1:0] ra2, logic signed [AB-1:0] d2);
            longint s1, c1, s2, c2, sd, cd, nx, ny, den, num, mag, ang;
            logic [31:0] dra;
            longint      r;
            dra = {ra2, 8'b0} - {ra1, 8'b0};
            rotate(dec_turns(d1), s1, c1);
            rotate(dec_turns(d2), s2, c2);
            rotate(dra, sd, cd);
            nx  = qprod(c2, sd);
            ny  = qprod(c1, s2) - qprod(qprod(s1, c2), cd);
            den = qprod(s1, s2) + qprod(qprod(c1, c2), cd);
            vector(nx < 0 ? -nx : nx, ny < 0 ? -ny : ny, mag, ang);
            num = qprod(mag, 652032874);
            if (num == 0) begin
                ang = den < 0 ? (64'sd1 <<< 31) : 0;
            end else begin
                vector(den, num, mag, ang);
                if (ang < 0) ang = 0;
                if (ang > (64'sd1 <<< 31)) ang = 64'sd1 <<< 31;
            end
            r = (ang + (64'sd1 <<< (31-AB))) >>> (32-AB);
            if (r > (64'sd1 <<< (AB-1))) r = 64'sd1 <<< (AB-1);
            pending_sep.push_back(r[AB-1:0]);
        endfunction

        function void check_separation(logic [AB-1:0] got);
            logic [AB-1:0] want;
            if (pending_sep.size() == 0) begin
                $display("%0t: separation %0d with nothing pending", $realtime, got);
                n_errors++;
                return;
            end
            want = pending_sep.pop_front();
            n_checked++;
            if (got !== want) begin
                $display("%0t: separation mismatch: expected %0d, actual %0d",
                         $realtime, want, got);
                n_errors++;
            end
        endfunction
    endclass

    separation_scoreboard sb = new();

    int  n_sent    = 0;
    int  idle_run  = 0;
    bit  send_done = 0;

    // -----------------------------------------------------------------------
    // Monitor: both handshakes sampled at the rising edge, before any update
    // -----------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall)
                sb.note_pair(i_ra_first, i_dec_first, i_ra_second, i_dec_second);
            if (o_valid && !i_stall)
                sb.check_separation(o_separation);
            // watchdog: count cycles without any transaction
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                idle_run <= 0;
            end else begin
                idle_run <= idle_run + 1;
                if (idle_run >= IDLE_MAX) begin
                    $display("tb: failure");
                    $finish;
                end
            end
        end
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Offer one pair and hold it until the block takes it.
    task automatic send_pair(logic [AB-1:0] ra1, logic [AB-1:0] d1,
                             logic [AB-1:0] ra2, logic [AB-1:0] d2);
        i_valid      <= 1'b1;
        i_ra_first   <= ra1;
        i_dec_first  <= d1;
        i_ra_second  <= ra2;
        i_dec_second <= d2;
        do @(posedge i_clk); while (o_stall);
        n_sent++;
    endtask

    // Drop valid for a random gap; skip the drop when no gap is drawn.
    task automatic idle_gap(bit quiet);
        int g;
        g = quiet ? 0 : pick_gap();
        if (g > 0) begin
            i_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    // Random declination: mostly in range, some raw words beyond the poles.
    function automatic logic [AB-1:0] rand_dec();
        if ($urandom_range(0, 9) == 0) return AB'($urandom);
        return AB'($urandom_range(0, 1 << 23) - (1 << 22));
    endfunction

    localparam logic [AB-1:0] POLE_N = 24'h400000;
    localparam logic [AB-1:0] POLE_S = 24'hC00000;
    localparam logic [AB-1:0] HALF   = 24'h800000;
    localparam logic [AB-1:0] QUART  = 24'h400000;
    localparam logic [AB-1:0] MAXV   = 24'hFFFFFF;

    // -----------------------------------------------------------------------
    // Sender
    // -----------------------------------------------------------------------
    initial begin
        logic [AB-1:0] ra1, d1, ra2, d2;
        int            mode;
        bit            burst;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed pairs
        send_pair('0, '0, '0, '0);                         // coincident
        send_pair('0, '0, HALF, '0);                       // antipodal on equator
        send_pair('0, POLE_N, '0, POLE_S);                 // pole to pole
        send_pair('0, POLE_N, 24'h123456, POLE_N);         // same pole, ra differs
        send_pair('0, '0, QUART, '0);                      // quarter turn
        send_pair(MAXV, '0, '0, '0);                       // ra wrap, one unit
        send_pair(MAXV, POLE_S, MAXV, POLE_N);
        send_pair('0, 24'h7FFFFF, '0, 24'h800000);         // beyond both poles
        send_pair('0, 24'h400001, 24'h333333, 24'hBFFFFF); // just past the poles
        send_pair(24'h0000FF, 24'h000001, 24'h800100, 24'hFFFFFF);
        send_pair('0, 24'h100000, HALF, 24'hF00000);       // antipodal, off the equator
        send_pair(24'hC00000, 24'h200000, 24'h400000, 24'hE00000);
        send_pair(24'hAAAAAA, 24'h555555, 24'h555555, 24'hAAAAAA);
        send_pair(24'h000001, 24'h3FFFFF, 24'h000000, 24'h3FFFFF);
        send_pair(24'h7FFFFF, 24'hC00001, 24'h800000, 24'h3FFFFF);
        send_pair(MAXV, MAXV, MAXV, MAXV);

        // random pairs
        burst = 0;
        for (int n = 0; n < N_RANDOM; n++) begin
            if ($urandom_range(0, 49) == 0) burst = ~burst;
            idle_gap(burst);
            mode = $urandom_range(0, 9);
            ra1 = AB'($urandom);
            d1  = rand_dec();
            if (mode < 5) begin
                ra2 = AB'($urandom);
                d2  = rand_dec();
            end else if (mode < 7) begin
                // close pair: small offsets
                ra2 = ra1 + AB'($urandom_range(0, 255)) - AB'(128);
                d2  = d1 + AB'($urandom_range(0, 255)) - AB'(128);
            end else if (mode < 9) begin
                // nearly antipodal pair
                ra2 = ra1 + HALF + AB'($urandom_range(0, 63)) - AB'(32);
                d2  = -d1 + AB'($urandom_range(0, 63)) - AB'(32);
            end else begin
                ra2 = ra1;
                d2  = d1;
            end
            send_pair(ra1, d1, ra2, d2);
        end
        i_valid   <= 1'b0;
        send_done = 1;
    end

    // -----------------------------------------------------------------------
    // Receiver stall: random bursts, one long hold-off while input keeps coming
    // -----------------------------------------------------------------------
    initial begin
        bit held = 0;
        int run;
        @(posedge i_rst_n);
        forever begin
            if (!held && n_sent >= 600) begin
                held = 1;
                i_stall <= 1'b1;
                repeat (400) @(posedge i_clk);
            end
            run = $urandom_range(0, 3) == 0 ? $urandom_range(20, 120) : pick_gap() + 1;
            i_stall <= 1'b0;
            repeat (run) @(posedge i_clk);
            run = pick_gap();
            if (run > 0) begin
                i_stall <= 1'b1;
                repeat (run) @(posedge i_clk);
            end
        end
    end

    // -----------------------------------------------------------------------
    // End of run
    // -----------------------------------------------------------------------
    initial begin
        wait (send_done);
        while (sb.pending_sep.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        $display("tb: %0d position pairs sent, %0d separations checked", n_sent, sb.n_checked);
        $display("tb: covered poles, out-of-range declinations, close, antipodal and random pairs");
        if (sb.n_errors == 0 && sb.pending_sep.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial sb.load_table();

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/asu_pkg.sv
hdl/asu_cordic_cell.sv
hdl/asu_cordic_chain.sv
hdl/angular_separation_unit_core.sv
hdl/asu_checker.sv
test/angular_separation_unit_core_tb.sv
